@@ sv/r2h_pkg.sv @@
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared types for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package r2h_pkg;

	// per-pixel side flags that ride along the divider pipeline
	typedef struct packed {
		logic black;   // value is zero: saturation forced to zero
		logic gray;    // chroma is zero: hue forced to zero
	} r2h_flags_t;

	// sector offsets in units of chroma
	localparam int unsigned SECTOR_GREEN = 2;
	localparam int unsigned SECTOR_BLUE  = 4;
	localparam int unsigned SECTOR_TURN  = 6;

endpackage

`default_nettype wire

@@ sv/r2h_ifs.sv @@
// ----------------------------------------------------------------------------
// r2h stream interfaces
// Valid/ready channels for RGB input words and HSV output words.
// ----------------------------------------------------------------------------
`default_nettype none

interface r2h_rgb_if #(parameter int W = 12);
	logic         valid;
	logic         ready;
	logic [W-1:0] red;
	logic [W-1:0] green;
	logic [W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface r2h_hsv_if #(parameter int W = 12);
	logic         valid;
	logic         ready;
	logic [W-1:0] hue;
	logic [W-1:0] saturation;
	logic [W-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

@@ sv/r2h_front.sv @@
// ----------------------------------------------------------------------------
// r2h_front
// Input register, max/min/chroma, sector position and divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_front #(
	parameter int P = 12
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_valid,
	input  wire  [P-1:0]        red,
	input  wire  [P-1:0]        green,
	input  wire  [P-1:0]        blue,
	output logic                valid_s2,
	output logic [P-1:0]        sat_rem_s2,
	output logic [P-1:0]        sat_num_s2,
	output logic [P-1:0]        sat_d_s2,
	output logic [P+2:0]        hue_rem_s2,
	output logic [P+2:0]        hue_d_s2,
	output logic [P-1:0]        val_s2,
	output r2h_pkg::r2h_flags_t flags_s2
);
	import r2h_pkg::*;

	logic                valid_s1;
	logic [P-1:0]        r_s1, g_s1, b_s1;
	logic [P-1:0]        mx_s1, mn_s1;
	logic [P-1:0]        mx, mn, c;
	logic signed [P+3:0] pos, pos_w;
	logic [P+3:0]        c6;
	logic [2*P-1:0]      num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		// stage 1: max and min of the incoming word
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		// stage 2: chroma, sector position and divider operands
		c  = mx_s1 - mn_s1;
		c6 = (P+4)'(c) * (P+4)'(SECTOR_TURN);
		if (mx_s1 == r_s1)
			pos = $signed({4'b0, g_s1}) - $signed({4'b0, b_s1});
		else if (mx_s1 == g_s1)
			pos = $signed((P+4)'(c) * (P+4)'(SECTOR_GREEN))
				+ $signed({4'b0, b_s1}) - $signed({4'b0, r_s1});
		else
			pos = $signed((P+4)'(c) * (P+4)'(SECTOR_BLUE))
				+ $signed({4'b0, r_s1}) - $signed({4'b0, g_s1});
		// red sector can go negative: wrap by a full turn
		pos_w = pos[P+3] ? pos + $signed(c6) : pos;
		// chroma * (2^P - 1)
		num = ({c, {P{1'b0}}}) - (2*P)'(c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1       <= red;
			g_s1       <= green;
			b_s1       <= blue;
			mx_s1      <= mx;
			mn_s1      <= mn;
			sat_rem_s2 <= num[2*P-1:P];
			sat_num_s2 <= num[P-1:0];
			sat_d_s2   <= mx_s1;
			hue_rem_s2 <= pos_w[P+2:0];
			hue_d_s2   <= c6[P+2:0];
			val_s2     <= mx_s1;
			flags_s2   <= '{black: (mx_s1 == '0), gray: (c == '0)};
		end
	end

endmodule

`default_nettype wire

@@ sv/r2h_div_step.sv @@
// ----------------------------------------------------------------------------
// r2h_div_step
// One registered restoring-division step for saturation and for hue.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_div_step #(
	parameter int P = 12
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 valid_i,
	input  wire  [P-1:0]        sat_rem_i,
	input  wire  [P-1:0]        sat_num_i,
	input  wire  [P-1:0]        sat_d_i,
	input  wire  [P-1:0]        sat_q_i,
	input  wire  [P+2:0]        hue_rem_i,
	input  wire  [P+2:0]        hue_d_i,
	input  wire  [P-1:0]        hue_q_i,
	input  wire  [P-1:0]        val_i,
	input  r2h_pkg::r2h_flags_t flags_i,
	output logic                valid_o,
	output logic [P-1:0]        sat_rem_o,
	output logic [P-1:0]        sat_num_o,
	output logic [P-1:0]        sat_d_o,
	output logic [P-1:0]        sat_q_o,
	output logic [P+2:0]        hue_rem_o,
	output logic [P+2:0]        hue_d_o,
	output logic [P-1:0]        hue_q_o,
	output logic [P-1:0]        val_o,
	output r2h_pkg::r2h_flags_t flags_o
);
	import r2h_pkg::*;

	logic [P:0]   st;
	logic [P+3:0] ht;
	logic         sbit, hbit;

	always_comb begin
		st   = {sat_rem_i, sat_num_i[P-1]};
		ht   = {hue_rem_i, 1'b0};
		sbit = (st >= {1'b0, sat_d_i});
		hbit = (ht >= {1'b0, hue_d_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_o <= 1'b0;
		else if (en)
			valid_o <= valid_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_rem_o <= sbit ? P'(st - {1'b0, sat_d_i}) : st[P-1:0];
			sat_num_o <= {sat_num_i[P-2:0], 1'b0};
			sat_d_o   <= sat_d_i;
			sat_q_o   <= {sat_q_i[P-2:0], sbit};
			hue_rem_o <= hbit ? (P+3)'(ht - {1'b0, hue_d_i}) : ht[P+2:0];
			hue_d_o   <= hue_d_i;
			hue_q_o   <= {hue_q_i[P-2:0], hbit};
			val_o     <= val_i;
			flags_o   <= flags_i;
		end
	end

endmodule

`default_nettype wire

@@ sv/rgb_to_hsv_pixel_top.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// RGB to HSV pixel converter, one word per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Takes one pixel word per cycle while the output word is taken and returns
// hue, saturation and brightness. Two front stages find max, min,
// chroma and the hue sector; then PIXEL_BITS divider stages each resolve one
// quotient bit of both divisions. The whole pipeline advances together and
// holds when the output word is not taken, so input ready follows output
// ready whenever the last stage is full.
`default_nettype none

module rgb_to_hsv_pixel_top #(
	parameter int PIXEL_BITS = 12
) (
	input wire               clk,
	input wire               arst_n,
	r2h_rgb_if.sink          rgb_in,
	r2h_hsv_if.source        hsv_out
);
	import r2h_pkg::*;

	localparam int P = PIXEL_BITS;

	logic               en;
	logic [P:0]         vld;
	logic [P-1:0]       sat_rem [P+1];
	logic [P-1:0]       sat_num [P+1];
	logic [P-1:0]       sat_d   [P+1];
	logic [P-1:0]       sat_q   [P+1];
	logic [P+2:0]       hue_rem [P+1];
	logic [P+2:0]       hue_d   [P+1];
	logic [P-1:0]       hue_q   [P+1];
	logic [P-1:0]       val     [P+1];
	r2h_flags_t         flags   [P+1];

	assign en           = hsv_out.ready || !vld[P];
	assign rgb_in.ready = en;

	r2h_front #(.P(P)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (rgb_in.valid),
		.red        (rgb_in.red),
		.green      (rgb_in.green),
		.blue       (rgb_in.blue),
		.valid_s2   (vld[0]),
		.sat_rem_s2 (sat_rem[0]),
		.sat_num_s2 (sat_num[0]),
		.sat_d_s2   (sat_d[0]),
		.hue_rem_s2 (hue_rem[0]),
		.hue_d_s2   (hue_d[0]),
		.val_s2     (val[0]),
		.flags_s2   (flags[0])
	);

	assign sat_q[0] = '0;
	assign hue_q[0] = '0;

	for (genvar i = 0; i < P; i++) begin : g_step
		r2h_div_step #(.P(P)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_i   (vld[i]),
			.sat_rem_i (sat_rem[i]),
			.sat_num_i (sat_num[i]),
			.sat_d_i   (sat_d[i]),
			.sat_q_i   (sat_q[i]),
			.hue_rem_i (hue_rem[i]),
			.hue_d_i   (hue_d[i]),
			.hue_q_i   (hue_q[i]),
			.val_i     (val[i]),
			.flags_i   (flags[i]),
			.valid_o   (vld[i+1]),
			.sat_rem_o (sat_rem[i+1]),
			.sat_num_o (sat_num[i+1]),
			.sat_d_o   (sat_d[i+1]),
			.sat_q_o   (sat_q[i+1]),
			.hue_rem_o (hue_rem[i+1]),
			.hue_d_o   (hue_d[i+1]),
			.hue_q_o   (hue_q[i+1]),
			.val_o     (val[i+1]),
			.flags_o   (flags[i+1])
		);
	end

	assign hsv_out.valid      = vld[P];
	assign hsv_out.brightness = val[P];
	assign hsv_out.saturation = flags[P].black ? '0 : sat_q[P];
	assign hsv_out.hue        = flags[P].gray  ? '0 : hue_q[P];

endmodule

`default_nettype wire

@@ sv/r2h_checker.sv @@
// ----------------------------------------------------------------------------
// r2h_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module r2h_checker #(
	parameter int W = 12
) (
	input wire         clk,
	input wire         arst_n,
	input wire         in_ready,
	input wire         out_valid,
	input wire         out_ready,
	input wire [W-1:0] hue,
	input wire [W-1:0] saturation,
	input wire [W-1:0] brightness
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("output word changed under stall");

	// empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// black pixel has no saturation and no hue
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	// zero saturation means zero chroma, so hue is zero
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation == '0 |-> hue == '0)
		else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel_top r2h_checker #(.W(PIXEL_BITS)) u_r2h_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (rgb_in.ready),
	.out_valid  (hsv_out.valid),
	.out_ready  (hsv_out.ready),
	.hue        (hsv_out.hue),
	.saturation (hsv_out.saturation),
	.brightness (hsv_out.brightness)
);

`default_nettype wire
